/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the triangle edge splitter.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, checked on every rising edge outside reset.
`define TERS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication.
`define TERS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TERS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TERS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/ters_pkg.sv */
// Package for the triangle edge splitter: id and mask types, opcodes,
// tag-mask codes, default parameters and the two-tag rotation helper.
// No dependencies.
`timescale 1ns / 1ps

package ters_pkg;

  localparam int ID_BITS          = 12;
  localparam int MASK_BITS        = 3;
  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int COORD_BITS_DEF   = 24;
  localparam int MOD_SHIFT        = 26;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [MASK_BITS-1:0] mask_t;

  typedef enum logic {
    OP_REFINE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  localparam mask_t MASK_NONE  = 3'd0;
  localparam mask_t MASK_AB    = 3'd1;
  localparam mask_t MASK_AC    = 3'd2;
  localparam mask_t MASK_AB_AC = 3'd3;
  localparam mask_t MASK_BC    = 3'd4;
  localparam mask_t MASK_AB_BC = 3'd5;
  localparam mask_t MASK_AC_BC = 3'd6;
  localparam mask_t MASK_ALL   = 3'd7;

  typedef struct packed {
    id_t   a;
    id_t   b;
    id_t   c;
    id_t   mab;
    id_t   mac;
    id_t   mbc;
    mask_t mask;
  } item_t;

  typedef struct packed {
    id_t p0;
    id_t p1;
    id_t p2;
  } tri_t;

  // Two-tag case turned so that v0 is the corner shared by both tagged edges.
  typedef struct packed {
    id_t v0;
    id_t v1;
    id_t v2;
    id_t x1;
    id_t x2;
  } quad_t;

  function automatic quad_t rotate(item_t it);
    quad_t q;
    case (it.mask)
      MASK_AB_AC: begin
        q.v0 = it.a; q.v1 = it.b; q.v2 = it.c; q.x1 = it.mab; q.x2 = it.mac;
      end
      MASK_AB_BC: begin
        q.v0 = it.b; q.v1 = it.c; q.v2 = it.a; q.x1 = it.mbc; q.x2 = it.mab;
      end
      default: begin
        q.v0 = it.c; q.v1 = it.a; q.v2 = it.b; q.x1 = it.mac; q.x2 = it.mbc;
      end
    endcase
    return q;
  endfunction

endpackage

/* sv/triangle_edge_refine_split.sv */
// Triangle edge splitter top level: coordinate store, distance pipeline
// and triangle output sequencer. Uses ters_pkg, ters_ram, assert_macros.svh.
//
//   channel | direction | handshake          | carries
//   in_     | input     | in_valid/in_stall  | load or refine item
//   out_    | output    | out_valid/out_stall| one triangle, last flag
//
// A refine item passes stages 1 to 4 and the sequencer register before its
// first triangle, then puts out 1, 2, 3 or 4 triangles in turn, holding
// while out_stall is high; the output port sets the sustained rate. A load
// is one input transfer and emits nothing. rst_n is synchronous and clears
// the valid bits and sequencer index, not the stored coordinates. The whole
// pipeline holds while its last stage has an item the sequencer cannot take.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_edge_refine_split #(
  parameter int VERTEX_DEPTH = ters_pkg::VERTEX_DEPTH_DEF,
  parameter int COORD_BITS   = ters_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  ters_pkg::id_t                in_corner_a,
  input  ters_pkg::id_t                in_corner_b,
  input  ters_pkg::id_t                in_corner_c,
  input  ters_pkg::id_t                in_mid_ab,
  input  ters_pkg::id_t                in_mid_ac,
  input  ters_pkg::id_t                in_mid_bc,
  input  ters_pkg::mask_t              in_refine_mask,
  input  ters_pkg::id_t                in_coord_addr,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ters_pkg::id_t                out_tri_first,
  output ters_pkg::id_t                out_tri_second,
  output ters_pkg::id_t                out_tri_third,
  output logic                         out_last_triangle
);

  localparam int AW        = $clog2(VERTEX_DEPTH);
  localparam int CW3       = 3 * COORD_BITS;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int IDW       = ters_pkg::ID_BITS;
  localparam int PROD_W    = IDW + ters_pkg::MOD_SHIFT;
  localparam int MOD_RECIP =
    ((1 << ters_pkg::MOD_SHIFT) + VERTEX_DEPTH - 1) / VERTEX_DEPTH;
  localparam bit SLOT_DIRECT =
    (VERTEX_DEPTH >= (1 << IDW)) || ((VERTEX_DEPTH & (VERTEX_DEPTH - 1)) == 0);

  // id modulo store depth; reciprocal multiply is exact for 12-bit ids
  function automatic logic [AW-1:0] slot_of(ters_pkg::id_t id);
    logic [PROD_W-1:0] prod;
    logic [IDW-1:0]    quo;
    logic [IDW-1:0]    rem;
    prod = PROD_W'(id) * PROD_W'(MOD_RECIP);
    quo  = IDW'(prod >> ters_pkg::MOD_SHIFT);
    rem  = id - IDW'(quo * IDW'(VERTEX_DEPTH));
    if (SLOT_DIRECT) begin
      return AW'(id);
    end else begin
      return AW'(rem);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] abs_diff(
    logic signed [COORD_BITS-1:0] u,
    logic signed [COORD_BITS-1:0] v
  );
    logic signed [COORD_BITS:0] d;
    d = {u[COORD_BITS-1], u} - {v[COORD_BITS-1], v};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return COORD_BITS'(d);
  endfunction

  // Input side
  ters_pkg::item_t in_item;
  ters_pkg::quad_t in_quad;
  logic            in_accept;
  logic            adv;
  logic            ram_we;
  logic            ram_re;

  always_comb begin
    in_item.a    = in_corner_a;
    in_item.b    = in_corner_b;
    in_item.c    = in_corner_c;
    in_item.mab  = in_mid_ab;
    in_item.mac  = in_mid_ac;
    in_item.mbc  = in_mid_bc;
    in_item.mask = in_refine_mask;
    in_quad      = ters_pkg::rotate(in_item);
  end

  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign ram_we    = in_accept && (in_opcode == ters_pkg::OP_LOAD);
  assign ram_re    = in_accept && (in_opcode == ters_pkg::OP_REFINE);

  // Two copies: pair P = (x1, v2), pair Q = (x2, v1)
  logic [CW3-1:0] p0_data, p1_data, q0_data, q1_data;

  ters_ram #(.WIDTH(CW3), .DEPTH(VERTEX_DEPTH)) u_ram_p (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (slot_of(in_coord_addr)),
    .wdata  ({in_coord_z, in_coord_y, in_coord_x}),
    .re     (ram_re),
    .raddr0 (slot_of(in_quad.x1)),
    .raddr1 (slot_of(in_quad.v2)),
    .rdata0 (p0_data),
    .rdata1 (p1_data)
  );

  ters_ram #(.WIDTH(CW3), .DEPTH(VERTEX_DEPTH)) u_ram_q (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (slot_of(in_coord_addr)),
    .wdata  ({in_coord_z, in_coord_y, in_coord_x}),
    .re     (ram_re),
    .raddr0 (slot_of(in_quad.x2)),
    .raddr1 (slot_of(in_quad.v1)),
    .rdata0 (q0_data),
    .rdata1 (q1_data)
  );

  // Stage 1: store read
  logic            s1_vld_r;
  ters_pkg::item_t s1_item_r;

  // Stage 2: per-axis magnitudes
  logic                  s2_vld_r;
  ters_pkg::item_t       s2_item_r;
  logic [COORD_BITS-1:0] s2_dp_r [3];
  logic [COORD_BITS-1:0] s2_dq_r [3];

  // Stage 3: squares
  logic            s3_vld_r;
  ters_pkg::item_t s3_item_r;
  logic [SQ_W-1:0] s3_sp_r [3];
  logic [SQ_W-1:0] s3_sq_r [3];

  // Stage 4: squared distances
  logic             s4_vld_r;
  ters_pkg::item_t  s4_item_r;
  logic [SUM_W-1:0] s4_sum_p_r;
  logic [SUM_W-1:0] s4_sum_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= ram_re;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r  <= in_item;
      s2_item_r  <= s1_item_r;
      s3_item_r  <= s2_item_r;
      s4_item_r  <= s3_item_r;
      s4_sum_p_r <= SUM_W'(s3_sp_r[0]) + SUM_W'(s3_sp_r[1]) + SUM_W'(s3_sp_r[2]);
      s4_sum_q_r <= SUM_W'(s3_sq_r[0]) + SUM_W'(s3_sq_r[1]) + SUM_W'(s3_sq_r[2]);
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_dp_r[ax] <= abs_diff(p0_data[ax*COORD_BITS +: COORD_BITS],
                                p1_data[ax*COORD_BITS +: COORD_BITS]);
        s2_dq_r[ax] <= abs_diff(q0_data[ax*COORD_BITS +: COORD_BITS],
                                q1_data[ax*COORD_BITS +: COORD_BITS]);
        s3_sp_r[ax] <= SQ_W'(s2_dp_r[ax]) * SQ_W'(s2_dp_r[ax]);
        s3_sq_r[ax] <= SQ_W'(s2_dq_r[ax]) * SQ_W'(s2_dq_r[ax]);
      end
    end
  end

  // Output sequencer
  logic           exp_vld_r;
  logic [1:0]     exp_idx_r;
  logic [1:0]     exp_cnt_r;
  ters_pkg::tri_t exp_tri_r [4];
  logic           exp_last;
  logic           out_fire;
  logic           exp_take;

  ters_pkg::tri_t  tri_nxt [4];
  logic [1:0]      cnt_nxt;
  ters_pkg::quad_t s4_quad;
  logic            p_shorter;

  assign exp_last = (exp_idx_r == exp_cnt_r);
  assign out_fire = exp_vld_r && !out_stall;
  assign exp_take = !exp_vld_r || (out_fire && exp_last);
  assign adv      = !s4_vld_r || exp_take;

  always_comb begin
    s4_quad   = ters_pkg::rotate(s4_item_r);
    p_shorter = s4_sum_p_r < s4_sum_q_r;
    for (int k = 0; k < 4; k++) begin
      tri_nxt[k] = '0;
    end
    cnt_nxt = 2'd0;
    case (s4_item_r.mask)
      ters_pkg::MASK_NONE: begin
        tri_nxt[0] = '{s4_item_r.a, s4_item_r.b, s4_item_r.c};
      end
      ters_pkg::MASK_AB: begin
        tri_nxt[0] = '{s4_item_r.a, s4_item_r.mab, s4_item_r.c};
        tri_nxt[1] = '{s4_item_r.mab, s4_item_r.b, s4_item_r.c};
        cnt_nxt    = 2'd1;
      end
      ters_pkg::MASK_AC: begin
        tri_nxt[0] = '{s4_item_r.a, s4_item_r.b, s4_item_r.mac};
        tri_nxt[1] = '{s4_item_r.mac, s4_item_r.b, s4_item_r.c};
        cnt_nxt    = 2'd1;
      end
      ters_pkg::MASK_BC: begin
        tri_nxt[0] = '{s4_item_r.a, s4_item_r.b, s4_item_r.mbc};
        tri_nxt[1] = '{s4_item_r.a, s4_item_r.mbc, s4_item_r.c};
        cnt_nxt    = 2'd1;
      end
      ters_pkg::MASK_ALL: begin
        tri_nxt[0] = '{s4_item_r.a, s4_item_r.mab, s4_item_r.mac};
        tri_nxt[1] = '{s4_item_r.mab, s4_item_r.b, s4_item_r.mbc};
        tri_nxt[2] = '{s4_item_r.mab, s4_item_r.mbc, s4_item_r.mac};
        tri_nxt[3] = '{s4_item_r.mac, s4_item_r.mbc, s4_item_r.c};
        cnt_nxt    = 2'd3;
      end
      default: begin
        tri_nxt[0] = '{s4_quad.v0, s4_quad.x1, s4_quad.x2};
        if (p_shorter) begin
          tri_nxt[1] = '{s4_quad.x2, s4_quad.x1, s4_quad.v2};
          tri_nxt[2] = '{s4_quad.x1, s4_quad.v1, s4_quad.v2};
        end else begin
          tri_nxt[1] = '{s4_quad.x2, s4_quad.x1, s4_quad.v1};
          tri_nxt[2] = '{s4_quad.x2, s4_quad.v1, s4_quad.v2};
        end
        cnt_nxt = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_vld_r <= 1'b0;
      exp_idx_r <= 2'd0;
    end else if (exp_take) begin
      exp_vld_r <= s4_vld_r;
      exp_idx_r <= 2'd0;
    end else if (out_fire) begin
      exp_idx_r <= exp_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exp_take && s4_vld_r) begin
      exp_cnt_r <= cnt_nxt;
      for (int k = 0; k < 4; k++) begin
        exp_tri_r[k] <= tri_nxt[k];
      end
    end
  end

  ters_pkg::tri_t cur_tri;

  assign cur_tri           = exp_tri_r[exp_idx_r];
  assign out_valid         = exp_vld_r;
  assign out_tri_first     = cur_tri.p0;
  assign out_tri_second    = cur_tri.p1;
  assign out_tri_third     = cur_tri.p2;
  assign out_last_triangle = exp_last;

  `TERS_ASSERT(a_refine_enters, clk, rst_n, (in_valid && !in_stall && in_opcode == ters_pkg::OP_REFINE) |=> s1_vld_r, "refine transfer did not enter the pipeline")
  `TERS_ASSERT(a_drain_idle, clk, rst_n, (out_valid && !out_stall && out_last_triangle && !s4_vld_r) |=> !out_valid, "output valid after last triangle with nothing queued")
  `TERS_ASSERT_IMP(a_idx_bound, clk, rst_n, exp_vld_r, exp_idx_r <= exp_cnt_r, "sequencer index ran past triangle count")
  `TERS_ASSERT(a_s4_hold, clk, rst_n, (s4_vld_r && !exp_take) |=> (s4_vld_r && $stable(s4_sum_p_r) && $stable(s4_sum_q_r)), "stalled last stage lost its item")

endmodule

/* sv/ters_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ters_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* tb/tri_split_checker.sv */
// Checker for the triangle edge splitter: watches both channels, predicts the
// emitted triangles of each refine transfer and compares them in order.
// Depends on ters_pkg.
`timescale 1ns / 1ps

module tri_split_checker
  import ters_pkg::*;
#(
  parameter int COORD_BITS = ters_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_opcode,
  input  id_t                          in_corner_a,
  input  id_t                          in_corner_b,
  input  id_t                          in_corner_c,
  input  id_t                          in_mid_ab,
  input  id_t                          in_mid_ac,
  input  id_t                          in_mid_bc,
  input  mask_t                        in_refine_mask,
  input  id_t                          in_coord_addr,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  id_t                          out_tri_first,
  input  id_t                          out_tri_second,
  input  id_t                          out_tri_third,
  input  logic                         out_last_triangle,
  output int                           pending,
  output int                           mismatches
);

  typedef struct {
    id_t  first;
    id_t  second;
    id_t  third;
    logic last;
  } tri_result_t;

  tri_result_t expected_tris[$];
  logic signed [COORD_BITS-1:0] x_coord [0:4095];
  logic signed [COORD_BITS-1:0] y_coord [0:4095];
  logic signed [COORD_BITS-1:0] z_coord [0:4095];
  int err_count = 0;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void queue_tri(id_t p, id_t q, id_t r, logic last);
    tri_result_t t;
    t.first  = p;
    t.second = q;
    t.third  = r;
    t.last   = last;
    expected_tris.insert(expected_tris.size(), t);
  endfunction

  function automatic longint sq_dist(id_t p, id_t q);
    longint dx, dy, dz;
    dx = longint'(x_coord[p]) - longint'(x_coord[q]);
    dy = longint'(y_coord[p]) - longint'(y_coord[q]);
    dz = longint'(z_coord[p]) - longint'(z_coord[q]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic void predict_split(id_t a, id_t b, id_t c, id_t mab, id_t mac,
                                        id_t mbc, mask_t m);
    id_t v0, v1, v2, x1, x2;
    case (m)
      MASK_NONE: begin
        queue_tri(a, b, c, 1'b1);
      end
      MASK_AB: begin
        queue_tri(a, mab, c, 1'b0);
        queue_tri(mab, b, c, 1'b1);
      end
      MASK_AC: begin
        queue_tri(a, b, mac, 1'b0);
        queue_tri(mac, b, c, 1'b1);
      end
      MASK_BC: begin
        queue_tri(a, b, mbc, 1'b0);
        queue_tri(a, mbc, c, 1'b1);
      end
      MASK_ALL: begin
        queue_tri(a, mab, mac, 1'b0);
        queue_tri(mab, b, mbc, 1'b0);
        queue_tri(mab, mbc, mac, 1'b0);
        queue_tri(mac, mbc, c, 1'b1);
      end
      default: begin
        // two tagged edges: turn so v0 is the shared corner
        if (m == MASK_AB_AC) begin
          v0 = a; v1 = b; v2 = c; x1 = mab; x2 = mac;
        end else if (m == MASK_AB_BC) begin
          v0 = b; v1 = c; v2 = a; x1 = mbc; x2 = mab;
        end else begin
          v0 = c; v1 = a; v2 = b; x1 = mac; x2 = mbc;
        end
        queue_tri(v0, x1, x2, 1'b0);
        if (sq_dist(x1, v2) < sq_dist(x2, v1)) begin
          queue_tri(x2, x1, v2, 1'b0);
          queue_tri(x1, v1, v2, 1'b1);
        end else begin
          queue_tri(x2, x1, v1, 1'b0);
          queue_tri(x2, v1, v2, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tri_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD) begin
          x_coord[in_coord_addr] = in_coord_x;
          y_coord[in_coord_addr] = in_coord_y;
          z_coord[in_coord_addr] = in_coord_z;
        end else begin
          predict_split(in_corner_a, in_corner_b, in_corner_c, in_mid_ab, in_mid_ac,
                        in_mid_bc, in_refine_mask);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_tris.size() == 0) begin
          report($sformatf("triangle %0d %0d %0d with none expected",
                           out_tri_first, out_tri_second, out_tri_third));
        end else begin
          want = expected_tris.pop_front();
          if (out_tri_first !== want.first)
            report($sformatf("tri_first got %0d want %0d", out_tri_first, want.first));
          if (out_tri_second !== want.second)
            report($sformatf("tri_second got %0d want %0d", out_tri_second, want.second));
          if (out_tri_third !== want.third)
            report($sformatf("tri_third got %0d want %0d", out_tri_third, want.third));
          if (out_last_triangle !== want.last)
            report($sformatf("last_triangle got %b want %b", out_last_triangle, want.last));
        end
      end
    end
    pending    <= expected_tris.size();
    mismatches <= err_count;
  end

endmodule

/* tb/tb_top.sv */
// Top of the triangle edge splitter testbench: clock, reset, directed and
// random load/refine stimulus, output stall pattern and the verdict.
// Depends on ters_pkg, triangle_edge_refine_split and tri_split_checker.
`timescale 1ns / 1ps

module tb_top;
  import ters_pkg::*;

  localparam int CB = ters_pkg::COORD_BITS_DEF;
  typedef logic signed [CB-1:0] coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  logic   clk               = 1'b0;
  logic   rst_n             = 1'b0;
  logic   in_valid          = 1'b0;
  logic   in_opcode         = 1'b0;
  id_t    in_corner_a       = '0;
  id_t    in_corner_b       = '0;
  id_t    in_corner_c       = '0;
  id_t    in_mid_ab         = '0;
  id_t    in_mid_ac         = '0;
  id_t    in_mid_bc         = '0;
  mask_t  in_refine_mask    = '0;
  id_t    in_coord_addr     = '0;
  coord_t in_coord_x        = '0;
  coord_t in_coord_y        = '0;
  coord_t in_coord_z        = '0;
  logic   out_stall         = 1'b0;
  logic   in_stall;
  logic   out_valid;
  id_t    out_tri_first;
  id_t    out_tri_second;
  id_t    out_tri_third;
  logic   out_last_triangle;

  int pending;
  int mismatches;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_run  = 0;
  id_t pool[$];
  bit  loaded [0:4095];

  always #5 clk = ~clk;

  triangle_edge_refine_split u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_corner_a       (in_corner_a),
    .in_corner_b       (in_corner_b),
    .in_corner_c       (in_corner_c),
    .in_mid_ab         (in_mid_ab),
    .in_mid_ac         (in_mid_ac),
    .in_mid_bc         (in_mid_bc),
    .in_refine_mask    (in_refine_mask),
    .in_coord_addr     (in_coord_addr),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tri_first     (out_tri_first),
    .out_tri_second    (out_tri_second),
    .out_tri_third     (out_tri_third),
    .out_last_triangle (out_last_triangle)
  );

  tri_split_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_corner_a       (in_corner_a),
    .in_corner_b       (in_corner_b),
    .in_corner_c       (in_corner_c),
    .in_mid_ab         (in_mid_ab),
    .in_mid_ac         (in_mid_ac),
    .in_mid_bc         (in_mid_bc),
    .in_refine_mask    (in_refine_mask),
    .in_coord_addr     (in_coord_addr),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tri_first     (out_tri_first),
    .out_tri_second    (out_tri_second),
    .out_tri_third     (out_tri_third),
    .out_last_triangle (out_last_triangle),
    .pending           (pending),
    .mismatches        (mismatches)
  );

  // receiver stall pattern, mode changes at the end of each random-length run
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 80);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 99) < 35);
      end
      2: begin
        out_stall <= ((stall_run % 16) < 6);
      end
      default: begin
        out_stall <= ~out_stall;
      end
    endcase
  end

  function automatic id_t rand_id();
    return id_t'($urandom_range(0, 4095));
  endfunction

  function automatic coord_t rand_coord(int style);
    int pick;
    pick = $urandom_range(0, 3);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 6) - 3);
      default: begin
        case (pick)
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic id_t pool_id();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic send(op_t op, id_t a, id_t b, id_t c, id_t mab, id_t mac, id_t mbc,
                      mask_t m, id_t addr, coord_t x, coord_t y, coord_t z);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_corner_a    <= a;
    in_corner_b    <= b;
    in_corner_c    <= c;
    in_mid_ab      <= mab;
    in_mid_ac      <= mac;
    in_mid_bc      <= mbc;
    in_refine_mask <= m;
    in_coord_addr  <= addr;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
    end
  endtask

  task automatic load(id_t addr, coord_t x, coord_t y, coord_t z);
    if (!loaded[addr]) begin
      loaded[addr] = 1'b1;
      pool.insert(pool.size(), addr);
    end
    send(OP_LOAD, rand_id(), rand_id(), rand_id(), rand_id(), rand_id(), rand_id(),
         mask_t'($urandom_range(0, 7)), addr, x, y, z);
  endtask

  task automatic refine(id_t a, id_t b, id_t c, id_t mab, id_t mac, id_t mbc, mask_t m);
    send(OP_REFINE, a, b, c, mab, mac, mbc, m, rand_id(),
         rand_coord(0), rand_coord(0), rand_coord(0));
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int    r;
    int    style;
    mask_t m;
    id_t   addr;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coordinate extremes, plus four coincident points for equal diagonals
    load(12'd0, COORD_MAX, COORD_MAX, COORD_MAX);
    load(12'd4095, COORD_MIN, COORD_MIN, COORD_MIN);
    load(12'd1, '0, '0, '0);
    load(12'd2, '0, '0, '0);
    load(12'd3, '0, '0, '0);
    load(12'd4, '0, '0, '0);

    refine('0, '0, '0, '0, '0, '0, MASK_NONE);
    refine('1, '1, '1, '1, '1, '1, MASK_NONE);
    refine(12'd10, 12'd11, 12'd12, 12'd13, 12'd14, 12'd15, MASK_AB);
    refine(12'd10, 12'd11, 12'd12, 12'd13, 12'd14, 12'd15, MASK_AC);
    refine(12'd10, 12'd11, 12'd12, 12'd13, 12'd14, 12'd15, MASK_BC);
    refine(12'd4095, 12'd0, 12'd4094, 12'd1, 12'd4093, 12'd2, MASK_ALL);

    // equal diagonals in every rotation
    refine(12'd1, 12'd2, 12'd3, 12'd4, 12'd1, 12'd2, MASK_AB_AC);
    refine(12'd1, 12'd2, 12'd3, 12'd4, 12'd1, 12'd2, MASK_AB_BC);
    refine(12'd1, 12'd2, 12'd3, 12'd4, 12'd1, 12'd2, MASK_AC_BC);

    // widest distances, both cut directions
    refine(12'd5, 12'd2, 12'd4095, 12'd0, 12'd1, 12'd9, MASK_AB_AC);
    refine(12'd5, 12'd4095, 12'd2, 12'd1, 12'd0, 12'd9, MASK_AB_AC);
    refine(12'd4095, 12'd6, 12'd1, 12'd0, 12'd7, 12'd2, MASK_AB_BC);
    refine(12'd1, 12'd2, 12'd8, 12'd9, 12'd3, 12'd0, MASK_AC_BC);
    drain_wait();

    for (int i = 0; i < 150; i++) begin
      if (i == 75) drain_wait();
      r = $urandom_range(0, 99);
      if (r < 25) begin
        style = $urandom_range(0, 9);
        style = (style < 5) ? 0 : (style < 8) ? 1 : 2;
        addr  = ($urandom_range(0, 1) == 0) ? rand_id() : pool_id();
        load(addr, rand_coord(style), rand_coord(style), rand_coord(style));
      end else begin
        m = mask_t'($urandom_range(0, 7));
        if (m == MASK_AB_AC || m == MASK_AB_BC || m == MASK_AC_BC) begin
          refine(pool_id(), pool_id(), pool_id(), pool_id(), pool_id(), pool_id(), m);
        end else begin
          refine(rand_id(), rand_id(), rand_id(), rand_id(), rand_id(), rand_id(), m);
        end
      end
    end

    drain_wait();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
